// ===== rtl/mfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg: shared definitions for the marker frame deframer
// Byte codes, status codes and the byte-wide CRC-16/ARC update.
// ----------------------------------------------------------------------------
package mfd_pkg;

   localparam logic [7:0]  MARKER_BYTE    = 8'h3E;
   localparam logic [15:0] CRC_POLY_REFL  = 16'hA001;
   localparam logic [15:0] CRC_INIT       = 16'h0000;
   localparam logic [15:0] MAX_PAYLOAD_RST = 16'hFFFF;
   localparam logic [1:0]  MARKER_LAST    = 2'd2;

   typedef enum logic [1:0] {
      STATUS_CRC_OK  = 2'd0,
      STATUS_CRC_BAD = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } status_type;

   // One byte of reflected CRC-16/ARC, LSB first.
   function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/marker_frame_deframer_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_frame_deframer_crc16: marker-framed packet deframer with CRC-16/ARC
//
// Input channel req_*: one received byte per transfer. Bytes are dropped until
// three '>' bytes in a row; then topic, sequence, length (MSB first) and CRC
// (MSB first) are taken, and each payload byte comes out on rsp_* tagged with
// topic and sequence. The last payload byte carries frame_end and the CRC
// status; a zero-length frame gives one status-only result after the header.
// A length above csr_max_payload gives one result with status "too long" as
// soon as the length low byte arrives, and hunting resumes.
// An accepted byte's result is registered in the output register. Throughput:
// one byte per cycle while the receiver takes results; the byte-wide CRC update
// and the header sequencer are both combinational.
// When the receiver stalls, the result holds in the output register and
// req_ready drops until it is taken; req_ready is high whenever that register
// is empty or being emptied in the same cycle.
// Reset (synchronous): hunting, marker count and header fields cleared,
// csr_max_payload set to 65535, no result pending. csr_ready is always high.
// ----------------------------------------------------------------------------
module marker_frame_deframer_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_topic,
   output logic [7:0]  rsp_sequence_res,
   output logic        rsp_frame_end,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_payload
);

   typedef enum logic [2:0] {
      PH_HUNT, PH_TOPIC, PH_SEQ, PH_LEN_HI, PH_LEN_LO, PH_CRC_HI, PH_CRC_LO, PH_PAYLOAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  marker_ff, marker_in;
   logic [7:0]  topic_ff, topic_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] exp_crc_ff, exp_crc_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] max_ff;

   logic        rsp_valid_ff;
   logic        dv_ff, fend_ff;
   logic [7:0]  byte_ff, rtopic_ff, rseq_ff;
   logic [1:0]  status_ff;

   logic        accept;
   logic        emit;
   logic        emit_dv, emit_fend;
   logic [1:0]  emit_status;
   logic [15:0] len_full, crc_full, crc_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign len_full = {remain_ff[15:8], req_rx_byte};
   assign crc_full = {exp_crc_ff[15:8], req_rx_byte};
   assign crc_next = mfd_pkg::crc_arc_byte(crc_ff, req_rx_byte);

   always_comb begin
      phase_in    = phase_ff;
      marker_in   = marker_ff;
      topic_in    = topic_ff;
      seq_in      = seq_ff;
      remain_in   = remain_ff;
      exp_crc_in  = exp_crc_ff;
      crc_in      = crc_ff;
      emit        = 1'b0;
      emit_dv     = 1'b0;
      emit_fend   = 1'b0;
      emit_status = mfd_pkg::STATUS_CRC_OK;
      unique case (phase_ff)
         PH_HUNT: begin
            if (req_rx_byte == mfd_pkg::MARKER_BYTE) begin
               if (marker_ff == mfd_pkg::MARKER_LAST) begin
                  marker_in = '0;
                  phase_in  = PH_TOPIC;
               end else begin
                  marker_in = marker_ff + 2'd1;
               end
            end else begin
               marker_in = '0;
            end
         end
         PH_TOPIC: begin
            topic_in = req_rx_byte;
            phase_in = PH_SEQ;
         end
         PH_SEQ: begin
            seq_in   = req_rx_byte;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            remain_in = {req_rx_byte, 8'h00};
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            remain_in = len_full;
            if (len_full > max_ff) begin
               phase_in    = PH_HUNT;
               marker_in   = '0;
               emit        = 1'b1;
               emit_fend   = 1'b1;
               emit_status = mfd_pkg::STATUS_TOO_LONG;
            end else begin
               phase_in = PH_CRC_HI;
            end
         end
         PH_CRC_HI: begin
            exp_crc_in = {req_rx_byte, 8'h00};
            phase_in   = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            exp_crc_in = crc_full;
            crc_in     = mfd_pkg::CRC_INIT;
            if (remain_ff == '0) begin
               // empty payload: its CRC is the init value
               phase_in    = PH_HUNT;
               marker_in   = '0;
               emit        = 1'b1;
               emit_fend   = 1'b1;
               emit_status = (crc_full == mfd_pkg::CRC_INIT) ? mfd_pkg::STATUS_CRC_OK
                                                             : mfd_pkg::STATUS_CRC_BAD;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            crc_in    = crc_next;
            remain_in = remain_ff - 16'd1;
            emit      = 1'b1;
            emit_dv   = 1'b1;
            if (remain_ff == 16'd1) begin
               phase_in    = PH_HUNT;
               marker_in   = '0;
               emit_fend   = 1'b1;
               emit_status = (crc_next == exp_crc_ff) ? mfd_pkg::STATUS_CRC_OK
                                                      : mfd_pkg::STATUS_CRC_BAD;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         marker_ff    <= '0;
         topic_ff     <= '0;
         seq_ff       <= '0;
         remain_ff    <= '0;
         exp_crc_ff   <= '0;
         crc_ff       <= mfd_pkg::CRC_INIT;
         max_ff       <= mfd_pkg::MAX_PAYLOAD_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            max_ff <= csr_max_payload;
         end
         if (accept) begin
            phase_ff   <= phase_in;
            marker_ff  <= marker_in;
            topic_ff   <= topic_in;
            seq_ff     <= seq_in;
            remain_ff  <= remain_in;
            exp_crc_ff <= exp_crc_in;
            crc_ff     <= crc_in;
         end
         // load on a producing transfer, clear once the result is taken
         if (accept) begin
            rsp_valid_ff <= emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         dv_ff     <= emit_dv;
         byte_ff   <= emit_dv ? req_rx_byte : 8'h00;
         rtopic_ff <= topic_in;
         rseq_ff   <= seq_in;
         fend_ff   <= emit_fend;
         status_ff <= emit_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_valid   = dv_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_topic        = rtopic_ff;
   assign rsp_sequence_res = rseq_ff;
   assign rsp_frame_end    = fend_ff;
   assign rsp_status       = status_ff;

endmodule

// ===== rtl/mfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_checker: port-level checks for the marker frame deframer
// Watches the result channel for handshake and result-format slips.
// ----------------------------------------------------------------------------
module mfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_data_valid,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_frame_end,
   input logic [1:0]  rsp_status
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_status) && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // the input side must open whenever the output register drains
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while the result is taken");

   // only payload transfers may leave the frame open
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> rsp_data_valid && rsp_status == mfd_pkg::STATUS_CRC_OK)
      else $error("open-frame result without payload or with status");

   // status-only results carry no byte; a length error is never a data transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_data_valid || rsp_status == mfd_pkg::STATUS_TOO_LONG)
         |-> rsp_frame_end && !rsp_data_valid && rsp_payload_byte == 8'h00)
      else $error("malformed status-only result");

   // nothing pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind marker_frame_deframer_crc16 mfd_checker u_mfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_data_valid   (rsp_data_valid),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_frame_end    (rsp_frame_end),
   .rsp_status       (rsp_status)
);
